### hdl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic clocked property, disabled while the active-low reset is low.
`define MME_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A signal holds its value in the cycle after a condition.
`define MME_ASSERT_HOLD(label, clk, rst_n, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
        else $error(msg);

`endif

### hdl/mme_pkg.sv
`default_nettype none

package mme_pkg;

    localparam int MAX_DIM    = 64;
    localparam int ELEM_WIDTH = 16;

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 6;
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 7;

    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W  = 2 * DIM_W;
    localparam int DEPTH   = 1 << ADDR_W;
    localparam int PROD_W  = 2 * ELEM_WIDTH;
    localparam int EXT_W   = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
    localparam logic [OP_W-1:0] OP_ROW     = 2'd2;

    localparam logic REG_INNER_SIZE     = 1'b0;
    localparam logic REG_RESULT_COLUMNS = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);
    localparam logic [CFG_W-1:0] MAX_DIM_C = CFG_W'(MAX_DIM);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic        [OP_W-1:0]    op;
        logic        [IDX_W-1:0]   row;
        logic        [IDX_W-1:0]   col;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic        [IDX_W-1:0] out_row;
        logic        [IDX_W-1:0] out_col;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_out_word;

    // Control that travels with one multiply-accumulate step.
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             last_k;
        logic             zero;
        logic             last_col;
        logic [DIM_W-1:0] col;
    } t_mac_ctl;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        return (v > MAX_DIM_C) ? MAX_DIM_C : v;
    endfunction

    // Keeps the low ELEM_WIDTH bits of the 16-bit field; wider elements
    // are zero-extended from the field.
    function automatic logic signed [ELEM_WIDTH-1:0] elem_from_value(
        input logic [VALUE_W-1:0] v
    );
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(v);
        return ELEM_WIDTH'(ext);
    endfunction

    function automatic logic idx_in_range(input logic [IDX_W-1:0] idx);
        return {1'b0, idx} < MAX_DIM_C;
    endfunction

endpackage

`default_nettype wire

### hdl/matrix_multiply_engine.sv
`default_nettype none

// Matrix multiply engine. Words on the input channel load one element of A
// or B (no result) or ask for one row of C = A * B, which comes out as
// result_columns words in column order, the last one marked. A row request
// runs max(inner_size, 1) * result_columns multiply-accumulate steps, where
// each size counts as at most 64: one multiply-accumulate per cycle while
// the output is not stalled, set by the single read port of each element
// store. Input is stalled while a row is being computed, and the whole
// pipeline pauses while a finished word is stalled at the output. The stores
// have no reset; reading an element that was never loaded gives an undefined
// sum.
module matrix_multiply_engine (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_stall,
    input  wire  mme_pkg::t_in_word               i_in_word,
    output logic                                  o_out_valid,
    input  wire                                   i_out_stall,
    output mme_pkg::t_out_word                    o_out_word,
    input  wire                                   psel,
    input  wire                                   penable,
    input  wire                                   pwrite,
    input  wire  [mme_pkg::APB_ADDR_W-1:0]        paddr,
    input  wire  [mme_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [mme_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    logic [mme_pkg::CFG_W-1:0] r_inner_size;
    logic [mme_pkg::CFG_W-1:0] r_result_columns;

    mme_pkg::t_state r_state, n_state;
    logic [mme_pkg::DIM_W-1:0] r_j, n_j, r_k, n_k;
    logic [mme_pkg::DIM_W-1:0] r_row, r_kend, r_jend;
    logic                      r_kzero;

    logic signed [mme_pkg::ELEM_WIDTH-1:0] a_mem [mme_pkg::DEPTH];
    logic signed [mme_pkg::ELEM_WIDTH-1:0] b_mem [mme_pkg::DEPTH];
    logic signed [mme_pkg::ELEM_WIDTH-1:0] r_a_rd, r_b_rd;
    logic signed [mme_pkg::PROD_W-1:0]     r_prod;
    logic signed [mme_pkg::SUM_W-1:0]      r_acc;
    logic signed [mme_pkg::SUM_W-1:0]      sum_now;

    mme_pkg::t_mac_ctl issue_ctl, r_s1, r_s2;
    mme_pkg::t_out_word r_out_word;
    logic               r_out_valid;

    logic in_acc, start, busy, adv, issue, cfg_wr;
    logic we_a, we_b;
    logic [mme_pkg::CFG_W-1:0]  k_count, n_count;
    logic [mme_pkg::ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;
    logic signed [mme_pkg::ELEM_WIDTH-1:0] wr_elem;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_size     <= mme_pkg::CFG_RESET;
            r_result_columns <= mme_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                mme_pkg::REG_INNER_SIZE:     r_inner_size     <= pwdata[mme_pkg::CFG_W-1:0];
                mme_pkg::REG_RESULT_COLUMNS: r_result_columns <= pwdata[mme_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mme_pkg::REG_INNER_SIZE:     prdata = mme_pkg::APB_DATA_W'(r_inner_size);
            mme_pkg::REG_RESULT_COLUMNS: prdata = mme_pkg::APB_DATA_W'(r_result_columns);
            default:                     prdata = '0;
        endcase
    end

    // ---------------- input decode ----------------
    assign busy       = (r_state == mme_pkg::ST_RUN) || r_s1.valid || r_s2.valid;
    assign o_in_stall = busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign k_count = mme_pkg::clamp_dim(r_inner_size);
    assign n_count = mme_pkg::clamp_dim(r_result_columns);

    assign start = in_acc && (i_in_word.op == mme_pkg::OP_ROW)
                   && mme_pkg::idx_in_range(i_in_word.row) && (n_count != '0);

    assign we_a = in_acc && (i_in_word.op == mme_pkg::OP_LOAD_A)
                  && mme_pkg::idx_in_range(i_in_word.row)
                  && mme_pkg::idx_in_range(i_in_word.col);
    assign we_b = in_acc && (i_in_word.op == mme_pkg::OP_LOAD_B)
                  && mme_pkg::idx_in_range(i_in_word.row)
                  && mme_pkg::idx_in_range(i_in_word.col);

    assign wr_addr = {i_in_word.row[mme_pkg::DIM_W-1:0], i_in_word.col[mme_pkg::DIM_W-1:0]};
    assign wr_elem = mme_pkg::elem_from_value(i_in_word.value);

    // The pipeline moves only when the output register can take a word.
    assign adv = !(r_out_valid && i_out_stall);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mme_pkg::ST_IDLE;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        issue   = 1'b0;
        unique case (r_state)
            mme_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = mme_pkg::ST_RUN;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            mme_pkg::ST_RUN: begin
                if (adv) begin
                    issue = 1'b1;
                    if (r_k == r_kend) begin
                        n_k = '0;
                        if (r_j == r_jend) begin
                            n_state = mme_pkg::ST_IDLE;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            default: n_state = mme_pkg::ST_IDLE;
        endcase
    end

    // Request parameters, captured once per row.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row   <= i_in_word.row[mme_pkg::DIM_W-1:0];
            r_kzero <= (k_count == '0);
            r_kend  <= (k_count == '0) ? '0 : mme_pkg::DIM_W'(k_count - 1'b1);
            r_jend  <= mme_pkg::DIM_W'(n_count - 1'b1);
        end
    end

    always_comb begin
        issue_ctl.valid    = issue;
        issue_ctl.first    = (r_k == '0);
        issue_ctl.last_k   = (r_k == r_kend);
        issue_ctl.zero     = r_kzero;
        issue_ctl.last_col = (r_j == r_jend);
        issue_ctl.col      = r_j;
    end

    // ---------------- element stores ----------------
    assign a_rd_addr = {r_row, r_k};
    assign b_rd_addr = {r_k, r_j};

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            a_mem[wr_addr] <= wr_elem;
        end
        if (adv) begin
            r_a_rd <= a_mem[a_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            b_mem[wr_addr] <= wr_elem;
        end
        if (adv) begin
            r_b_rd <= b_mem[b_rd_addr];
        end
    end

    // ---------------- multiply-accumulate pipeline ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
            r_s2 <= '0;
        end else if (adv) begin
            r_s1 <= issue_ctl;
            r_s2 <= r_s1;
        end
    end

    assign sum_now = (r_s2.first ? '0 : r_acc) + mme_pkg::SUM_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // With a zero inner size one step per column runs with a zero product.
            if (r_s1.zero) begin
                r_prod <= '0;
            end else begin
                r_prod <= r_a_rd * r_b_rd;
            end
            if (r_s2.valid) begin
                r_acc <= sum_now;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s2.valid && r_s2.last_k) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2.valid && r_s2.last_k) begin
            r_out_word.out_row <= mme_pkg::IDX_W'(r_row);
            r_out_word.out_col <= mme_pkg::IDX_W'(r_s2.col);
            r_out_word.sum     <= sum_now;
            r_out_word.last    <= r_s2.last_col;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

### hdl/mme_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mme_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  i_in_valid,
    input wire                                  o_in_stall,
    input wire mme_pkg::t_in_word               i_in_word,
    input wire                                  o_out_valid,
    input wire                                  i_out_stall,
    input wire mme_pkg::t_out_word              o_out_word
);

    logic load_acc;
    logic out_held;
    logic mid_row;

    assign load_acc = i_in_valid && !o_in_stall && (i_in_word.op != mme_pkg::OP_ROW);
    assign out_held = o_out_valid && i_out_stall;
    assign mid_row  = o_out_valid && !o_out_word.last;

    `MME_ASSERT(a_out_valid_hold, i_clk, i_rst_n, out_held |=> o_out_valid, "word dropped")
    `MME_ASSERT_HOLD(a_out_word_hold, i_clk, i_rst_n, out_held, o_out_word, "word changed")
    // Until the last column of a row has gone out, no new word may enter.
    `MME_ASSERT(a_row_blocks_input, i_clk, i_rst_n, mid_row |-> o_in_stall, "input mid-row")
    // A load or an unused code never makes the block busy.
    `MME_ASSERT(a_load_no_busy, i_clk, i_rst_n, load_acc |=> !o_in_stall, "load left busy")

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

`default_nettype wire

### sim/testbench.sv
module testbench;
    import mme_pkg::*;

    localparam logic [OP_W-1:0]       OP_UNUSED     = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_INNER    = {REG_INNER_SIZE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_COLS     = {REG_RESULT_COLUMNS, 2'b00};
    localparam int                    RANDOM_ITEMS  = 310;
    localparam int                    SETTLE_CYCLES = 80;
    localparam int                    REPORT_LIMIT  = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_in_word              in_word;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_word             out_word;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    matrix_multiply_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Shadow copy of the element stores and the dimension registers.
    logic signed [ELEM_WIDTH-1:0] a_elems [DEPTH];
    logic signed [ELEM_WIDTH-1:0] b_elems [DEPTH];
    bit                           a_loaded [DEPTH];
    bit                           b_loaded [DEPTH];
    logic [CFG_W-1:0]             inner_reg;
    logic [CFG_W-1:0]             cols_reg;
    t_out_word                    row_sums_q[$];
    t_out_word                    next_sum;

    int error_count    = 0;
    int items_sent     = 0;
    int words_checked  = 0;
    int rows_requested = 0;
    int dim_settings   = 0;
    int burst_left     = 0;
    int stall_mode     = 0;
    int mode_left      = 0;
    int stall_phase    = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int dim_in_use(input logic [CFG_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic t_in_word make_word(input logic [OP_W-1:0] op, input int row,
                                           input int col, input logic [VALUE_W-1:0] value);
        t_in_word w;
        w.op    = op;
        w.row   = IDX_W'(row);
        w.col   = IDX_W'(col);
        w.value = value;
        return w;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic void note_mismatch(input string what);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // Updates the shadow stores, or works out every column of a requested row.
    task automatic gemm_update(input t_in_word w);
        int                             idx;
        int                             kc;
        int                             nc;
        logic signed [SUM_W-1:0]        acc;
        logic signed [2*ELEM_WIDTH-1:0] prod;
        t_out_word                      r;
        idx = int'(w.row) * MAX_DIM + int'(w.col);
        case (w.op)
            OP_LOAD_A: begin
                a_elems[idx]  = w.value;
                a_loaded[idx] = 1'b1;
            end
            OP_LOAD_B: begin
                b_elems[idx]  = w.value;
                b_loaded[idx] = 1'b1;
            end
            OP_ROW: begin
                kc = dim_in_use(inner_reg);
                nc = dim_in_use(cols_reg);
                rows_requested++;
                for (int j = 0; j < nc; j++) begin
                    acc = '0;
                    for (int k = 0; k < kc; k++) begin
                        prod = a_elems[int'(w.row) * MAX_DIM + k] * b_elems[k * MAX_DIM + j];
                        acc += prod;
                    end
                    r.out_row = w.row;
                    r.out_col = IDX_W'(j);
                    r.sum     = acc;
                    r.last    = (j == nc - 1);
                    row_sums_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input t_in_word w);
        if (burst_left == 0) begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        in_word  = w;
        in_valid = 1'b1;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        gemm_update(w);
        if (w.op != OP_UNUSED)
            items_sent++;
        burst_left--;
        @(negedge i_clk);
        if (burst_left == 0)
            in_valid = 1'b0;
    endtask

    task automatic request_row(input int row);
        send_word(make_word(OP_ROW, row, $urandom_range(0, MAX_DIM - 1), random_value()));
    endtask

    // Loads whatever a row request still needs, so no unloaded element is read.
    task automatic fill_row(input int row, input int kc, input int nc);
        int kr;
        kr = (kc == 0) ? 1 : kc;
        for (int k = 0; k < kr; k++)
            if (!a_loaded[row * MAX_DIM + k])
                send_word(make_word(OP_LOAD_A, row, k, random_value()));
        for (int k = 0; k < kr; k++)
            for (int j = 0; j < nc; j++)
                if (!b_loaded[k * MAX_DIM + j])
                    send_word(make_word(OP_LOAD_B, k, j, random_value()));
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (row_sums_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rdata);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_reg(input logic [APB_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] rdata;
        apb_access(1'b0, addr, '0, rdata);
        if (rdata !== APB_DATA_W'(value))
            note_mismatch($sformatf("register at %0d expected %0d got %0h", addr, value, rdata));
    endtask

    // Only written once the engine is idle; upper data bits carry noise.
    task automatic set_dims(input logic [CFG_W-1:0] k_set, input logic [CFG_W-1:0] n_set);
        logic [APB_DATA_W-1:0] noise;
        logic [APB_DATA_W-1:0] unused;
        drain();
        noise = $urandom;
        apb_access(1'b1, ADDR_INNER, {noise[APB_DATA_W-1:CFG_W], k_set}, unused);
        noise = $urandom;
        apb_access(1'b1, ADDR_COLS, {noise[APB_DATA_W-1:CFG_W], n_set}, unused);
        inner_reg = k_set;
        cols_reg  = n_set;
        check_reg(ADDR_INNER, k_set);
        check_reg(ADDR_COLS, n_set);
        dim_settings++;
    endtask

    task automatic test_register_reset();
        check_reg(ADDR_INNER, CFG_RESET);
        check_reg(ADDR_COLS, CFG_RESET);
    endtask

    task automatic test_extreme_products();
        set_dims(7'd2, 7'd2);
        send_word(make_word(OP_LOAD_A, 0, 0, 16'h7FFF));
        send_word(make_word(OP_LOAD_A, 0, 1, 16'h8000));
        send_word(make_word(OP_LOAD_B, 0, 0, 16'h8000));
        send_word(make_word(OP_LOAD_B, 0, 1, 16'h7FFF));
        send_word(make_word(OP_LOAD_B, 1, 0, 16'h7FFF));
        send_word(make_word(OP_LOAD_B, 1, 1, 16'h8000));
        send_word(make_word(OP_LOAD_A, 63, 0, 16'hFFFF));
        send_word(make_word(OP_LOAD_A, 63, 1, 16'h0001));
        request_row(0);
        request_row(63);
    endtask

    task automatic test_zero_inner();
        set_dims(7'd0, 7'd2);
        request_row(0);
        request_row(63);
    endtask

    task automatic test_zero_columns();
        set_dims(7'd2, 7'd0);
        request_row(0);
        send_word(make_word(OP_UNUSED, 63, 63, 16'h8000));
        request_row(63);
    endtask

    // Phases of random traffic, each under its own dimension setting; the
    // early phases push each dimension to its limit and past it.
    task automatic test_random_phases();
        int               phase;
        int               target;
        int               pick;
        int               kc;
        int               nc;
        int               row;
        logic [CFG_W-1:0] k_set;
        logic [CFG_W-1:0] n_set;
        phase  = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            case (phase)
                0: begin
                    k_set = 7'd127;
                    n_set = 7'd1;
                end
                2: begin
                    k_set = 7'd1;
                    n_set = 7'd127;
                end
                4: begin
                    k_set = 7'd0;
                    n_set = 7'd64;
                end
                6: begin
                    k_set = 7'd64;
                    n_set = 7'd1;
                end
                default: begin
                    k_set = CFG_W'($urandom_range(0, 5));
                    n_set = CFG_W'($urandom_range(0, 5));
                end
            endcase
            set_dims(k_set, n_set);
            kc = dim_in_use(k_set);
            nc = dim_in_use(n_set);
            repeat ($urandom_range(8, 30)) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    if (kc > 8)
                        row = MAX_DIM - 1;
                    else if ($urandom_range(0, 4) != 0)
                        row = $urandom_range(0, 3);
                    else
                        row = $urandom_range(0, MAX_DIM - 1);
                    fill_row(row, kc, nc);
                    request_row(row);
                end else if (pick < 88) begin
                    if ($urandom_range(0, 4) != 0)
                        send_word(make_word($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                                            $urandom_range(0, 7), $urandom_range(0, 7),
                                            random_value()));
                    else
                        send_word(make_word($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                                            $urandom_range(0, MAX_DIM - 1),
                                            $urandom_range(0, MAX_DIM - 1), random_value()));
                end else if (pick < 95) begin
                    send_word(make_word(OP_UNUSED, $urandom_range(0, MAX_DIM - 1),
                                        $urandom_range(0, MAX_DIM - 1), random_value()));
                end else begin
                    drain();
                end
            end
            phase++;
        end
    endtask

    // Receiver stall pattern: off, light, heavy or periodic, switching now and then.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_phase % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) begin
            if (row_sums_q.size() == 0) begin
                note_mismatch($sformatf("unexpected word row %0d col %0d sum %0d last %0b",
                                        out_word.out_row, out_word.out_col, out_word.sum,
                                        out_word.last));
            end else begin
                next_sum = row_sums_q.pop_front();
                words_checked++;
                if (out_word.out_row !== next_sum.out_row ||
                    out_word.out_col !== next_sum.out_col ||
                    out_word.sum !== next_sum.sum || out_word.last !== next_sum.last)
                    note_mismatch($sformatf(
                        "expected row %0d col %0d sum %0d last %0b, got %0d %0d %0d %0b",
                        next_sum.out_row, next_sum.out_col, next_sum.sum, next_sum.last,
                        out_word.out_row, out_word.out_col, out_word.sum, out_word.last));
            end
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        inner_reg = CFG_RESET;
        cols_reg  = CFG_RESET;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_register_reset();
        test_extreme_products();
        test_zero_inner();
        test_zero_columns();
        test_random_phases();
        drain();
        $display("Ran %0d items with %0d row requests under %0d dimension settings,",
                 items_sent, rows_requested, dim_settings);
        $display("checked %0d result words, %0d mismatches.", words_checked, error_count);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

endmodule
